// ===== hdl/rgbm_pkg.sv =====
// rgbm_pkg: shared types and constants of the rgb median window filter
// pixel and result payload structs, register indexes, default sizes
// no dependencies
package rgbm_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_HALF   = 3;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LEVEL  = 2'd2;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgbm_pixel_t;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } rgbm_in_t;

    typedef struct packed {
        logic [9:0] out_col;
        logic [9:0] out_row;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       run_last;
        logic       frame_last;
    } rgbm_out_t;

    typedef struct packed {
        logic       start;
        logic       dec;
        logic [2:0] bit_pos;
    } rgbm_sel_ctrl_t;

endpackage

// ===== hdl/rgb_median_window_filter.sv =====
// rgb_median_window_filter: top level, config registers and window sequencer
// uses rgbm_pkg, rgbm_store and rgbm_select
//
// usage:
//   pixels enter in raster order on in_valid/in_ready/in_data, one beat per
//   pixel. each beat is written to the line store; if it completes windows,
//   the block then produces one result beat per completed window centre on
//   out_valid/out_ready/out_data, in raster order, run_last on the last one.
//   in_ready is high only while no window is in progress.
//   per result the window of n pixels is read eight times, one bit of the
//   median search per pass (n up to (2*MAX_HALF+1)^2, 49 by default); the
//   reads are bounded by the single store read port.
//   a pixel that completes no window leaves in_ready high for the next pixel.
//   a stalled receiver holds the result register and the whole sequencer.
//   reset: registers return to width 1024, height 1024, level 3, position
//   zero; the store content is left as is. any register write restarts the
//   frame. configuration goes over the apb port, registers at 0, 4, 8.
module rgb_median_window_filter
    import rgbm_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_HALF   = DEF_MAX_HALF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  rgbm_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output rgbm_out_t   out_data
);

    localparam int HELD = 2 * MAX_HALF + 1;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int SW   = $clog2(HELD);
    localparam int KW   = $clog2(MAX_HALF + 1);
    localparam int DW   = $clog2(HELD + 1);
    localparam int NW   = 2 * DW;
    localparam int AW   = $clog2(HELD * MAX_WIDTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_FIN   = 3'd3;
    localparam logic [2:0] ST_DEC   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    // configuration
    logic [10:0] fw_reg, fh_reg;
    logic [2:0]  lvl_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        case (cfg_idx)
            REG_WIDTH:  prdata = {21'd0, fw_reg};
            REG_HEIGHT: prdata = {21'd0, fh_reg};
            REG_LEVEL:  prdata = {29'd0, lvl_reg};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg  <= 11'd1024;
            fh_reg  <= 11'd1024;
            lvl_reg <= 3'd3;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_WIDTH:  fw_reg  <= pwdata[10:0];
                REG_HEIGHT: fh_reg  <= pwdata[10:0];
                REG_LEVEL:  lvl_reg <= pwdata[2:0];
                default:    ;
            endcase
        end
    end

    // effective sizes
    logic [WW-1:0] w_eff;
    logic [HW-1:0] ht_eff;
    logic [CW-1:0] w_m1;
    logic [RW-1:0] ht_m1;
    logic [KW-1:0] h_eff;

    always_comb
    begin
        if (fw_reg == 11'd0)
            w_eff = WW'(1);
        else if (int'(fw_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(fw_reg);
        if (fh_reg == 11'd0)
            ht_eff = HW'(1);
        else if (int'(fh_reg) > MAX_HEIGHT)
            ht_eff = HW'(MAX_HEIGHT);
        else
            ht_eff = HW'(fh_reg);
        if (int'(lvl_reg >> 1) > MAX_HALF)
            h_eff = KW'(MAX_HALF);
        else
            h_eff = KW'(lvl_reg >> 1);
        w_m1  = CW'(w_eff - WW'(1));
        ht_m1 = RW'(ht_eff - HW'(1));
    end

    // sequencer registers
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [SW-1:0] slot_reg;
    logic [RW-1:0] proc_row_reg;
    logic [SW-1:0] proc_slot_reg;
    logic [CW-1:0] x_reg, xlo_reg, xhi_reg, x1_reg, x2_reg, xi_reg;
    logic [RW-1:0] y_reg, yhi_reg, y1_reg, y2_reg, yi_reg;
    logic [NW-1:0] rank_reg;
    logic [2:0]    bit_reg;

    // position of the accepted pixel
    logic          in_acc;
    logic [CW-1:0] c_cur;
    logic [RW-1:0] r_cur;
    logic [SW-1:0] s_cur;
    logic          cspan_ok, rspan_ok;
    logic [CW-1:0] cspan_lo, cspan_hi;
    logic [RW-1:0] rspan_lo, rspan_hi;
    logic [CW-1:0] hc;
    logic [RW-1:0] hr;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign hc       = CW'(h_eff);
    assign hr       = RW'(h_eff);

    always_comb
    begin
        if ((WW'(col_reg) >= w_eff) || (HW'(row_reg) >= ht_eff))
        begin
            c_cur = '0;
            r_cur = '0;
            s_cur = '0;
        end
        else
        begin
            c_cur = col_reg;
            r_cur = row_reg;
            s_cur = slot_reg;
        end
        cspan_ok = 1'b1;
        if (c_cur == w_m1)
        begin
            cspan_lo = (c_cur >= hc) ? c_cur - hc : '0;
            cspan_hi = c_cur;
        end
        else if (c_cur >= hc)
        begin
            cspan_lo = c_cur - hc;
            cspan_hi = c_cur - hc;
        end
        else
        begin
            cspan_lo = '0;
            cspan_hi = '0;
            cspan_ok = 1'b0;
        end
        rspan_ok = 1'b1;
        if (r_cur == ht_m1)
        begin
            rspan_lo = (r_cur >= hr) ? r_cur - hr : '0;
            rspan_hi = r_cur;
        end
        else if (r_cur >= hr)
        begin
            rspan_lo = r_cur - hr;
            rspan_hi = r_cur - hr;
        end
        else
        begin
            rspan_lo = '0;
            rspan_hi = '0;
            rspan_ok = 1'b0;
        end
    end

    // clipped window of the current centre
    logic [CW-1:0] x1_c, x2_c;
    logic [RW-1:0] y1_c, y2_c;
    logic [NW-1:0] n_c;
    logic [CW:0]   xsum;
    logic [RW:0]   ysum;

    always_comb
    begin
        xsum = {1'b0, x_reg} + {1'b0, hc};
        ysum = {1'b0, y_reg} + {1'b0, hr};
        x1_c = (x_reg >= hc) ? x_reg - hc : '0;
        y1_c = (y_reg >= hr) ? y_reg - hr : '0;
        x2_c = (xsum > {1'b0, w_m1})  ? w_m1  : CW'(xsum);
        y2_c = (ysum > {1'b0, ht_m1}) ? ht_m1 : RW'(ysum);
        n_c  = NW'(DW'(x2_c - x1_c + CW'(1))) * NW'(DW'(y2_c - y1_c + RW'(1)));
    end

    // store addressing
    logic [SW-1:0] diff;
    logic [SW:0]   slot_w;
    logic [SW-1:0] rd_slot;
    logic [AW-1:0] raddr, waddr;
    logic          re;

    always_comb
    begin
        diff = SW'(proc_row_reg - yi_reg);
        if (proc_slot_reg >= diff)
            slot_w = {1'b0, proc_slot_reg} - {1'b0, diff};
        else
            slot_w = {1'b0, proc_slot_reg} + (SW + 1)'(HELD) - {1'b0, diff};
        rd_slot = SW'(slot_w);
        raddr = AW'(AW'(rd_slot) * AW'(MAX_WIDTH)) + AW'(xi_reg);
        waddr = AW'(AW'(s_cur) * AW'(MAX_WIDTH)) + AW'(c_cur);
        re    = (state_reg == ST_READ);
    end

    rgbm_pixel_t wpix, rpix, ans;
    logic        rvalid;
    rgbm_sel_ctrl_t sel_ctrl;

    assign wpix.red   = in_data.red_in;
    assign wpix.green = in_data.green_in;
    assign wpix.blue  = in_data.blue_in;

    assign sel_ctrl.start   = (state_reg == ST_SETUP);
    assign sel_ctrl.dec     = (state_reg == ST_DEC);
    assign sel_ctrl.bit_pos = bit_reg;

    rgbm_store #(
        .DEPTH (HELD * MAX_WIDTH),
        .AW    (AW)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (in_acc),
        .waddr  (waddr),
        .wdata  (wpix),
        .re     (re),
        .raddr  (raddr),
        .rdata  (rpix),
        .rvalid (rvalid)
    );

    rgbm_select #(
        .NW (NW)
    ) u_select (
        .clk       (clk),
        .ctrl      (sel_ctrl),
        .rank      (rank_reg),
        .pix       (rpix),
        .pix_valid (rvalid),
        .ans       (ans)
    );

    logic last_centre;
    assign last_centre = (x_reg == xhi_reg) && (y_reg == yhi_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_acc && cspan_ok && rspan_ok)
                    state_next = ST_SETUP;
            ST_SETUP:
                state_next = ST_READ;
            ST_READ:
                if (xi_reg == x2_reg && yi_reg == y2_reg)
                    state_next = ST_FIN;
            ST_FIN:
                state_next = ST_DEC;
            ST_DEC:
                state_next = (bit_reg == 3'd0) ? ST_OUT : ST_READ;
            ST_OUT:
                if (out_ready)
                    state_next = last_centre ? ST_IDLE : ST_SETUP;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr && (cfg_idx inside {REG_WIDTH, REG_HEIGHT, REG_LEVEL}))
            begin
                col_reg  <= '0;
                row_reg  <= '0;
                slot_reg <= '0;
            end
            else if (in_acc)
            begin
                if (c_cur != w_m1)
                begin
                    col_reg  <= c_cur + CW'(1);
                    row_reg  <= r_cur;
                    slot_reg <= s_cur;
                end
                else
                begin
                    col_reg <= '0;
                    if (r_cur != ht_m1)
                    begin
                        row_reg  <= r_cur + RW'(1);
                        slot_reg <= (int'(s_cur) == HELD - 1) ? '0 : s_cur + SW'(1);
                    end
                    else
                    begin
                        row_reg  <= '0;
                        slot_reg <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (in_acc)
                begin
                    proc_row_reg  <= r_cur;
                    proc_slot_reg <= s_cur;
                    x_reg   <= cspan_lo;
                    xlo_reg <= cspan_lo;
                    xhi_reg <= cspan_hi;
                    y_reg   <= rspan_lo;
                    yhi_reg <= rspan_hi;
                end
            ST_SETUP:
            begin
                x1_reg   <= x1_c;
                x2_reg   <= x2_c;
                y1_reg   <= y1_c;
                y2_reg   <= y2_c;
                xi_reg   <= x1_c;
                yi_reg   <= y1_c;
                rank_reg <= (n_c - NW'(1)) >> 1;
                bit_reg  <= 3'd7;
            end
            ST_READ:
                if (xi_reg == x2_reg)
                begin
                    xi_reg <= x1_reg;
                    yi_reg <= (yi_reg == y2_reg) ? y1_reg : yi_reg + RW'(1);
                end
                else
                begin
                    xi_reg <= xi_reg + CW'(1);
                end
            ST_DEC:
                if (bit_reg != 3'd0)
                    bit_reg <= bit_reg - 3'd1;
            ST_OUT:
                if (out_ready && !last_centre)
                begin
                    if (x_reg == xhi_reg)
                    begin
                        x_reg <= xlo_reg;
                        y_reg <= y_reg + RW'(1);
                    end
                    else
                    begin
                        x_reg <= x_reg + CW'(1);
                    end
                end
            default:
                ;
        endcase
    end

    assign out_valid           = (state_reg == ST_OUT);
    assign out_data.out_col    = 10'(x_reg);
    assign out_data.out_row    = 10'(y_reg);
    assign out_data.red_out    = ans.red;
    assign out_data.green_out  = ans.green;
    assign out_data.blue_out   = ans.blue;
    assign out_data.run_last   = last_centre;
    assign out_data.frame_last = (x_reg == w_m1) && (y_reg == ht_m1);

`ifndef ASSERT_OFF
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input taken while a result is pending");

    a_frame_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.frame_last) |-> out_data.run_last)
        else $error("frame end result not last of its run");

    a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_data.run_last) |=> in_ready)
        else $error("not idle after last result beat");

    a_read_data: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid |-> (state_reg == ST_READ || state_reg == ST_FIN))
        else $error("store data outside a counting pass");
`endif

endmodule

// ===== hdl/rgbm_store.sv =====
// rgbm_store: line store memory, one write and one read port
// read data registered; depends on rgbm_pkg
module rgbm_store
    import rgbm_pkg::*;
#(
    parameter int DEPTH = 7 * DEF_MAX_WIDTH,
    parameter int AW    = $clog2(7 * DEF_MAX_WIDTH)
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        we,
    input  logic [AW-1:0] waddr,
    input  rgbm_pixel_t wdata,
    input  logic        re,
    input  logic [AW-1:0] raddr,
    output rgbm_pixel_t rdata,
    output logic        rvalid
);

    rgbm_pixel_t mem [DEPTH];
    logic rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= re;
        end
    end

    assign rvalid = rvalid_reg;

endmodule

// ===== hdl/rgbm_select.sv =====
// rgbm_select: bitwise order-statistic search for three channels
// counts window values below a trial value, one bit per pass; depends on rgbm_pkg
module rgbm_select
    import rgbm_pkg::*;
#(
    parameter int NW = 8
)
(
    input  logic           clk,
    input  rgbm_sel_ctrl_t ctrl,
    input  logic [NW-1:0]  rank,
    input  rgbm_pixel_t    pix,
    input  logic           pix_valid,
    output rgbm_pixel_t    ans
);

    rgbm_pixel_t   ans_reg;
    logic [NW-1:0] cnt_r_reg, cnt_g_reg, cnt_b_reg;
    logic [7:0]    bit_mask;
    rgbm_pixel_t   trial;

    always_comb
    begin
        bit_mask    = 8'd1 << ctrl.bit_pos;
        trial.red   = ans_reg.red   | bit_mask;
        trial.green = ans_reg.green | bit_mask;
        trial.blue  = ans_reg.blue  | bit_mask;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            ans_reg   <= '0;
            cnt_r_reg <= '0;
            cnt_g_reg <= '0;
            cnt_b_reg <= '0;
        end
        else if (ctrl.dec)
        begin
            // keep the bit while at most rank values lie below the trial
            if (cnt_r_reg <= rank)
            begin
                ans_reg.red <= trial.red;
            end
            if (cnt_g_reg <= rank)
            begin
                ans_reg.green <= trial.green;
            end
            if (cnt_b_reg <= rank)
            begin
                ans_reg.blue <= trial.blue;
            end
            cnt_r_reg <= '0;
            cnt_g_reg <= '0;
            cnt_b_reg <= '0;
        end
        else if (pix_valid)
        begin
            cnt_r_reg <= cnt_r_reg + NW'(pix.red   < trial.red);
            cnt_g_reg <= cnt_g_reg + NW'(pix.green < trial.green);
            cnt_b_reg <= cnt_b_reg + NW'(pix.blue  < trial.blue);
        end
    end

    assign ans = ans_reg;

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench of rgb_median_window_filter
// drives pixel beats and apb register writes, predicts every median result
// depends on rgbm_pkg and rgb_median_window_filter
module tb_top
    import rgbm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HELD_ROWS = 2 * DEF_MAX_HALF + 1;
    localparam int IDLE_LIMIT = 40000;

    class median_scoreboard;
        logic [23:0] pix_rows [HELD_ROWS * DEF_MAX_WIDTH];
        int unsigned col_pos, row_pos;
        int unsigned width_reg, height_reg, level_reg;
        rgbm_out_t pending_results[$];
        int errors;

        function void reset_state();
            col_pos = 0;
            row_pos = 0;
            width_reg = 1024;
            height_reg = 1024;
            level_reg = 3;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, int unsigned value);
            if (idx == REG_WIDTH) width_reg = value & 11'h7ff;
            else if (idx == REG_HEIGHT) height_reg = value & 11'h7ff;
            else if (idx == REG_LEVEL) level_reg = value & 3'h7;
            col_pos = 0;
            row_pos = 0;
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned maxv);
            if (v == 0) return 1;
            if (v > maxv) return maxv;
            return v;
        endfunction

        // range of window centres that this position completes
        function bit centres_done(int unsigned p, int unsigned len, int unsigned hs,
                                  output int unsigned lo, output int unsigned hi);
            lo = 0;
            hi = 0;
            if (p == len - 1) begin
                lo = (p >= hs) ? p - hs : 0;
                hi = p;
                return 1;
            end
            if (p >= hs) begin
                lo = p - hs;
                hi = p - hs;
                return 1;
            end
            return 0;
        endfunction

        function void note_pixel(rgbm_in_t px);
            int unsigned w, ht, hs, c, r, ylo, yhi, xlo, xhi, x1, x2, y1, y2, mid;
            logic [7:0] rq[$], gq[$], bq[$];
            logic [23:0] p;
            rgbm_out_t res;
            int found;
            w = clamp_dim(width_reg, DEF_MAX_WIDTH);
            ht = clamp_dim(height_reg, DEF_MAX_HEIGHT);
            hs = level_reg >> 1;
            if (hs > DEF_MAX_HALF) hs = DEF_MAX_HALF;
            if (col_pos >= w || row_pos >= ht) begin
                col_pos = 0;
                row_pos = 0;
            end
            c = col_pos;
            r = row_pos;
            pix_rows[(r % HELD_ROWS) * DEF_MAX_WIDTH + c] = {px.blue_in, px.green_in, px.red_in};
            found = 0;
            if (centres_done(r, ht, hs, ylo, yhi) && centres_done(c, w, hs, xlo, xhi)) begin
                for (int unsigned y = ylo; y <= yhi; y++) begin
                    y1 = (y >= hs) ? y - hs : 0;
                    y2 = (y + hs > ht - 1) ? ht - 1 : y + hs;
                    for (int unsigned x = xlo; x <= xhi; x++) begin
                        x1 = (x >= hs) ? x - hs : 0;
                        x2 = (x + hs > w - 1) ? w - 1 : x + hs;
                        rq.delete();
                        gq.delete();
                        bq.delete();
                        for (int unsigned yi = y1; yi <= y2; yi++)
                            for (int unsigned xi = x1; xi <= x2; xi++) begin
                                p = pix_rows[(yi % HELD_ROWS) * DEF_MAX_WIDTH + xi];
                                rq.push_back(p[7:0]);
                                gq.push_back(p[15:8]);
                                bq.push_back(p[23:16]);
                            end
                        rq.sort();
                        gq.sort();
                        bq.sort();
                        mid = (rq.size() - 1) / 2;
                        res.out_col = x[9:0];
                        res.out_row = y[9:0];
                        res.red_out = rq[mid];
                        res.green_out = gq[mid];
                        res.blue_out = bq[mid];
                        res.run_last = 1'b0;
                        res.frame_last = (x == w - 1 && y == ht - 1);
                        pending_results.push_back(res);
                        found++;
                    end
                end
            end
            if (found > 0) pending_results[pending_results.size() - 1].run_last = 1'b1;
            if (c + 1 < w) col_pos = c + 1;
            else begin
                col_pos = 0;
                row_pos = (r + 1 < ht) ? r + 1 : 0;
            end
        endfunction

        function void check_result(rgbm_out_t got);
            rgbm_out_t exp_res;
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected: %p", $realtime, got);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (got.out_col !== exp_res.out_col)
                $display("%0t: out_col exp %0d got %0d", $realtime, exp_res.out_col, got.out_col);
            if (got.out_row !== exp_res.out_row)
                $display("%0t: out_row exp %0d got %0d", $realtime, exp_res.out_row, got.out_row);
            if (got.red_out !== exp_res.red_out)
                $display("%0t: red_out exp %0d got %0d", $realtime, exp_res.red_out, got.red_out);
            if (got.green_out !== exp_res.green_out)
                $display("%0t: green_out exp %0d got %0d", $realtime,
                         exp_res.green_out, got.green_out);
            if (got.blue_out !== exp_res.blue_out)
                $display("%0t: blue_out exp %0d got %0d", $realtime,
                         exp_res.blue_out, got.blue_out);
            if (got.run_last !== exp_res.run_last)
                $display("%0t: run_last exp %0b got %0b", $realtime,
                         exp_res.run_last, got.run_last);
            if (got.frame_last !== exp_res.frame_last)
                $display("%0t: frame_last exp %0b got %0b", $realtime,
                         exp_res.frame_last, got.frame_last);
            if (got !== exp_res) errors++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    rgbm_in_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    rgbm_out_t   out_data;

    median_scoreboard sb;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    int idle_cycles = 0;
    int random_items = 0;

    rgb_median_window_filter u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #5 clk = ~clk;

    // result monitor and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) sb.check_result(out_data);
            if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // receiver ready with stall bursts and one long hold-off
    initial begin
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic apb_write(logic [1:0] idx, int unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_pixel(rgbm_in_t px);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= px;
        do @(posedge clk); while (!in_ready);
        sb.note_pixel(px);
    endtask

    // all results drained, sequencer given time to settle
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic rgbm_in_t edge_pixel(int k);
        rgbm_in_t px;
        case (k % 4)
            0: px = '0;
            1: px = '1;
            2: px = 24'h55aa55;
            default: px = rgbm_in_t'($urandom);
        endcase
        return px;
    endfunction

    task automatic frame_phase(int unsigned w, int unsigned h, int unsigned lvl,
                               int nitems, bit edges);
        drain_results();
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, h);
        apb_write(REG_LEVEL, lvl);
        for (int k = 0; k < nitems; k++)
            send_pixel(edges ? edge_pixel(k) : rgbm_in_t'($urandom));
    endtask

    initial begin
        int unsigned w, h, n;
        sb = new();
        sb.reset_state();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults after reset: early pixels of a wide frame complete nothing
        for (int k = 0; k < 6; k++) send_pixel(edge_pixel(k));
        // zero sizes count as one, level 7 gives the largest half-size
        frame_phase(0, 0, 7, 4, 1'b1);
        frame_phase(3, 3, 2, 9, 1'b1);
        frame_phase(4, 2, 5, 8, 1'b1);

        // oversize sizes saturate
        frame_phase(2047, 1, 0, 20, 1'b0);
        frame_phase(1, 2047, 1, 20, 1'b0);
        frame_phase(2, 1024, 6, 20, 1'b0);

        // long receiver hold-off while the sender keeps going
        drain_results();
        apb_write(REG_WIDTH, 5);
        apb_write(REG_HEIGHT, 5);
        apb_write(REG_LEVEL, 3);
        hold_req = 1'b1;
        for (int k = 0; k < 25; k++) send_pixel(rgbm_in_t'($urandom));

        while (random_items < 340) begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            n = w * h * $urandom_range(1, 2) + $urandom_range(0, 3);
            if (random_items > 280) quiet = 1'b1;
            frame_phase(w, h, $urandom_range(0, 7), int'(n), 1'b0);
            random_items += int'(n);
        end

        drain_results();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/rgbm_pkg.sv
hdl/rgbm_store.sv
hdl/rgbm_select.sv
hdl/rgb_median_window_filter.sv
sim/tb_top.sv
